/* rtl/nsa_pkg.sv */
`timescale 1ns / 1ps

package nsa_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int MAX_DIMENSION   = 4096;

    localparam int CH_W     = 16;   // Q8.8 color channel, Q12.4 center
    localparam int SQ_IN_W  = 34;   // sum of squares
    localparam int ROOT_W   = SQ_IN_W / 2;
    localparam int COST_W   = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SP_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_WEIGHT   = 3'd3;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef struct packed {
        logic load_we;
        logic start;
        logic rd_en;
        logic rd_last;
    } t_cmd;

    typedef struct packed {
        logic in_image;
        logic count_zero;
        logic scan_done;
    } t_status;

endpackage

/* rtl/nsa_isqrt.sv */
`timescale 1ns / 1ps

// Pipelined integer square root, one root bit per stage.
module nsa_isqrt #(
    parameter int IN_W  = 34,
    parameter int TAG_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [IN_W-1:0]      i_rad,
    input  logic [TAG_W-1:0]     i_tag,
    output logic [IN_W/2-1:0]    o_root,
    output logic [TAG_W-1:0]     o_tag
);
    localparam int OUT_W = IN_W / 2;
    localparam int R     = OUT_W + 1;

    logic [R-1:0]     r_rem  [0:OUT_W-2];
    logic [IN_W-1:0]  r_data [0:OUT_W-2];
    logic [OUT_W-1:0] r_root [0:OUT_W-1];
    logic [TAG_W-1:0] r_tag  [0:OUT_W-1];

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        logic [R-1:0]     prev_rem;
        logic [OUT_W-1:0] prev_root;
        logic [IN_W-1:0]  prev_data;
        logic [TAG_W-1:0] prev_tag;
        logic [R+1:0]     cur;
        logic [R+1:0]     trial;
        logic [R+1:0]     diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign prev_rem  = '0;
            assign prev_root = '0;
            assign prev_data = i_rad;
            assign prev_tag  = i_tag;
        end else begin : g_next
            assign prev_rem  = r_rem[s-1];
            assign prev_root = r_root[s-1];
            assign prev_data = r_data[s-1];
            assign prev_tag  = r_tag[s-1];
        end

        assign cur   = {prev_rem, prev_data[IN_W-1 -: 2]};
        assign trial = {1'b0, prev_root, 2'b01};
        assign ge    = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            r_root[s] <= {prev_root[OUT_W-2:0], ge};
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= prev_tag;
            end
        end

        if (s < OUT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s]  <= ge ? diff[R-1:0] : cur[R-1:0];
                r_data[s] <= {prev_data[IN_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[OUT_W-1];
    assign o_tag  = r_tag[OUT_W-1];

endmodule

/* rtl/nsa_ctrl.sv */
`timescale 1ns / 1ps

module nsa_ctrl
    import nsa_pkg::*;
#(
    parameter int ADDR_W = 8,
    parameter int CNT_W  = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_opcode,
    input  logic [CNT_W-1:0]  i_count,
    input  t_status           i_status,
    input  logic              i_out_free,
    output logic              o_stall,
    output logic              o_out_load,
    output t_cmd              o_cmd,
    output logic [ADDR_W-1:0] o_rd_addr
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic              accept;
    logic              last;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign last    = ((CNT_W'(r_addr) + CNT_W'(1)) == i_count);

    always_comb begin
        o_cmd.load_we = accept && (i_opcode == OP_LOAD);
        o_cmd.start   = accept && (i_opcode == OP_CLASSIFY) && i_status.in_image;
        o_cmd.rd_en   = (r_state == S_SCAN);
        o_cmd.rd_last = (r_state == S_SCAN) && last;
    end

    assign o_rd_addr  = r_addr;
    assign o_out_load = (r_state == S_DONE) && i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_addr <= '0;
                    if (o_cmd.start) begin
                        r_state <= i_status.count_zero ? S_DONE : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + ADDR_W'(1);
                    if (last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (i_status.scan_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/nsa_datapath.sv */
`timescale 1ns / 1ps

module nsa_datapath
    import nsa_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int ADDR_W      = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    input  logic [7:0]             i_entry_index,
    input  logic signed [CH_W-1:0] i_color_l,
    input  logic signed [CH_W-1:0] i_color_a,
    input  logic signed [CH_W-1:0] i_color_b,
    input  logic [CH_W-1:0]        i_center_x,
    input  logic [CH_W-1:0]        i_center_y,
    input  logic [11:0]            i_pixel_col,
    input  logic [11:0]            i_pixel_row,
    input  logic [12:0]            i_image_width,
    input  logic [12:0]            i_image_height,
    input  logic                   i_count_zero,
    input  logic [15:0]            i_weight,
    output t_status                o_status,
    output logic [ADDR_W-1:0]      o_best
);
    localparam int IDX_W = (ADDR_W > 8) ? ADDR_W : 8;
    localparam int TAG_W = ADDR_W + 2;   // {valid, last, addr}

    logic [3*CH_W-1:0] r_mem_color  [0:MAX_ENTRIES-1];
    logic [2*CH_W-1:0] r_mem_center [0:MAX_ENTRIES-1];

    logic [IDX_W-1:0]  wr_idx;
    logic signed [CH_W-1:0] r_pix_l, r_pix_a, r_pix_b;
    logic [CH_W-1:0]   r_px, r_py;

    // read stage
    logic [3*CH_W-1:0] r_a_color;
    logic [2*CH_W-1:0] r_a_center;
    logic [TAG_W-1:0]  r_a_tag;

    // square stage
    logic signed [CH_W:0]   d_l, d_a, d_b, d_x, d_y;
    logic signed [2*CH_W+1:0] s_l, s_a, s_b, s_x, s_y;
    logic [2*CH_W-1:0] r_sq_l, r_sq_a, r_sq_b, r_sq_x, r_sq_y;
    logic [TAG_W-1:0]  r_b_tag;

    // sum stage
    logic [SQ_IN_W-1:0] r_csum, r_psum;
    logic [TAG_W-1:0]   r_c_tag;

    logic [ROOT_W-1:0] cd, pd;
    logic [TAG_W-1:0]  cd_tag;
    logic              pd_valid;

    logic [ROOT_W-1:0]      r_cd;
    logic [ROOT_W+15:0]     r_prod;
    logic [TAG_W-1:0]       r_d_tag;
    logic [COST_W-1:0]      r_cost;
    logic [TAG_W-1:0]       r_e_tag;
    logic [COST_W-1:0]      r_best_cost;
    logic [ADDR_W-1:0]      r_best;
    logic                   r_done;

    assign wr_idx = IDX_W'(i_entry_index);

    always_comb begin
        o_status.in_image   = ({1'b0, i_pixel_col} < i_image_width)
                           && ({1'b0, i_pixel_row} < i_image_height)
                           && (32'(i_pixel_col) < MAX_DIMENSION)
                           && (32'(i_pixel_row) < MAX_DIMENSION);
        o_status.count_zero = i_count_zero;
        o_status.scan_done  = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && (32'(wr_idx) < MAX_ENTRIES)) begin
            r_mem_color[wr_idx[ADDR_W-1:0]]  <= {i_color_l, i_color_a, i_color_b};
            r_mem_center[wr_idx[ADDR_W-1:0]] <= {i_center_x, i_center_y};
        end
        r_a_color  <= r_mem_color[i_rd_addr];
        r_a_center <= r_mem_center[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pix_l <= i_color_l;
            r_pix_a <= i_color_a;
            r_pix_b <= i_color_b;
            r_px    <= {i_pixel_col, 4'b0000};
            r_py    <= {i_pixel_row, 4'b0000};
        end
    end

    always_comb begin
        d_l = $signed({r_a_color[47], r_a_color[47:32]}) - $signed({r_pix_l[15], r_pix_l});
        d_a = $signed({r_a_color[31], r_a_color[31:16]}) - $signed({r_pix_a[15], r_pix_a});
        d_b = $signed({r_a_color[15], r_a_color[15:0]})  - $signed({r_pix_b[15], r_pix_b});
        d_x = $signed({1'b0, r_a_center[31:16]}) - $signed({1'b0, r_px});
        d_y = $signed({1'b0, r_a_center[15:0]})  - $signed({1'b0, r_py});
        s_l = d_l * d_l;
        s_a = d_a * d_a;
        s_b = d_b * d_b;
        s_x = d_x * d_x;
        s_y = d_y * d_y;
    end

    always_ff @(posedge i_clk) begin
        r_sq_l <= s_l[2*CH_W-1:0];
        r_sq_a <= s_a[2*CH_W-1:0];
        r_sq_b <= s_b[2*CH_W-1:0];
        r_sq_x <= s_x[2*CH_W-1:0];
        r_sq_y <= s_y[2*CH_W-1:0];
        r_csum <= SQ_IN_W'(r_sq_l) + SQ_IN_W'(r_sq_a) + SQ_IN_W'(r_sq_b);
        r_psum <= SQ_IN_W'(r_sq_x) + SQ_IN_W'(r_sq_y);
        r_cd   <= cd;
        r_prod <= (ROOT_W+16)'(i_weight) * (ROOT_W+16)'(pd);
        r_cost <= COST_W'({r_cd, 4'b0000}) + COST_W'(r_prod);
    end

    nsa_isqrt #(.IN_W(SQ_IN_W), .TAG_W(TAG_W)) u_color_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   (r_csum),
        .i_tag   (r_c_tag),
        .o_root  (cd),
        .o_tag   (cd_tag)
    );

    nsa_isqrt #(.IN_W(SQ_IN_W), .TAG_W(1)) u_pos_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   (r_psum),
        .i_tag   (r_c_tag[TAG_W-1]),
        .o_root  (pd),
        .o_tag   (pd_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
            r_b_tag <= '0;
            r_c_tag <= '0;
            r_d_tag <= '0;
            r_e_tag <= '0;
            r_done  <= 1'b0;
        end else begin
            r_a_tag <= {i_cmd.rd_en, i_cmd.rd_last, i_rd_addr};
            r_b_tag <= r_a_tag;
            r_c_tag <= r_b_tag;
            r_d_tag <= {cd_tag[TAG_W-1] & pd_valid, cd_tag[TAG_W-2:0]};
            r_e_tag <= r_d_tag;
            r_done  <= r_e_tag[TAG_W-1] && r_e_tag[TAG_W-2];
        end
    end

    // running minimum, strict compare keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_best_cost <= '1;
            r_best      <= '0;
        end else if (r_e_tag[TAG_W-1] && (r_cost < r_best_cost)) begin
            r_best_cost <= r_cost;
            r_best      <= r_e_tag[ADDR_W-1:0];
        end
    end

    assign o_best = r_best;

endmodule

/* rtl/nearest_superpixel_assign_top.sv */
`timescale 1ns / 1ps

// Load beat: no result; loads can follow back to back.
// Classify beat in the image: the table is scanned one entry per cycle, then the pipeline
// drains and the result is handed off; the scan is skipped when the count is zero.
// One pixel at a time: the next beat is taken only after the result is handed off, which waits
// while a result beat is stalled; a pixel outside the image gives no result and holds nothing up.
// Reset (sync, active low) restores registers to 4096/4096/1/256; table not cleared.
module nearest_superpixel_assign_top
    import nsa_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_opcode,
    input  logic [7:0]             i_entry_index,
    input  logic signed [CH_W-1:0] i_color_l,
    input  logic signed [CH_W-1:0] i_color_a,
    input  logic signed [CH_W-1:0] i_color_b,
    input  logic [CH_W-1:0]        i_center_x,
    input  logic [CH_W-1:0]        i_center_y,
    input  logic [11:0]            i_pixel_col,
    input  logic [11:0]            i_pixel_row,
    // result beats
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_superpixel_index,
    // register writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data
);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    // config registers
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;
    logic [8:0]  r_sp_count;
    logic [15:0] r_pos_weight;

    logic [CNT_W-1:0]  count_eff;
    t_cmd              cmd;
    t_status           status;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] best;
    logic              out_free;
    logic              out_load;

    logic              r_out_valid;
    logic [7:0]        r_out_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= 13'd4096;
            r_image_height <= 13'd4096;
            r_sp_count     <= 9'd1;
            r_pos_weight   <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[12:0];
                CFG_SP_COUNT:     r_sp_count     <= i_cfg_data[8:0];
                CFG_POS_WEIGHT:   r_pos_weight   <= i_cfg_data;
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    // counts beyond the table search the whole table
    assign count_eff = (32'(r_sp_count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(r_sp_count);

    // output register frees up in the same cycle its beat is taken
    assign out_free = !r_out_valid || !i_stall;

    nsa_ctrl #(.ADDR_W(ADDR_W), .CNT_W(CNT_W)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_opcode   (i_opcode),
        .i_count    (count_eff),
        .i_status   (status),
        .i_out_free (out_free),
        .o_stall    (o_stall),
        .o_out_load (out_load),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    nsa_datapath #(.MAX_ENTRIES(MAX_ENTRIES), .ADDR_W(ADDR_W)) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_rd_addr      (rd_addr),
        .i_entry_index  (i_entry_index),
        .i_color_l      (i_color_l),
        .i_color_a      (i_color_a),
        .i_color_b      (i_color_b),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_pixel_col    (i_pixel_col),
        .i_pixel_row    (i_pixel_row),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_count_zero   (count_eff == '0),
        .i_weight       (r_pos_weight),
        .o_status       (status),
        .o_best         (best)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_index <= 8'(best);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_superpixel_index = r_out_index;

endmodule
